>>> rtl/brp_pkg.sv
// Shared types and constants for the button autorepeat block.
`timescale 1ns / 1ps

package brp_pkg;

  localparam int NOW_W  = 32;
  localparam int INTV_W = 16;
  localparam int CODE_W = 4;

  localparam logic [CODE_W-1:0] CODE_NONE   = 4'd0;
  localparam logic [CODE_W-1:0] CODE_RIGHT  = 4'd1;
  localparam logic [CODE_W-1:0] CODE_LEFT   = 4'd2;
  localparam logic [CODE_W-1:0] CODE_DOWN   = 4'd4;
  localparam logic [CODE_W-1:0] CODE_ROTATE = 4'd8;

  localparam logic [INTV_W-1:0] INIT_DELAY_RST      = 16'd300;
  localparam logic [INTV_W-1:0] REPEAT_RATE_RST     = 16'd100;
  localparam logic [INTV_W-1:0] DOWN_INIT_DELAY_RST = 16'd300;
  localparam logic [INTV_W-1:0] DOWN_REPEAT_RST     = 16'd50;

  typedef enum logic [1:0] {
    REG_INIT_DELAY      = 2'd0,
    REG_REPEAT_RATE     = 2'd1,
    REG_DOWN_INIT_DELAY = 2'd2,
    REG_DOWN_REPEAT     = 2'd3
  } reg_idx_t;

  // per-button control from the priority logic
  typedef struct packed {
    logic en;
    logic pressed;
  } btn_ctl_t;

endpackage

>>> rtl/brp_poll_if.sv
// Input channel: one poll item with time stamp and button levels.
`timescale 1ns / 1ps

interface brp_poll_if import brp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [NOW_W-1:0] now_ms;
  logic             left_level;
  logic             right_level;
  logic             up_level;
  logic             down_level;

  modport source (output valid, now_ms, left_level, right_level, up_level, down_level,
                  input ready);
  modport sink (input valid, now_ms, left_level, right_level, up_level, down_level,
                output ready);
endinterface

>>> rtl/brp_move_if.sv
// Output channel: one move item per poll.
`timescale 1ns / 1ps

interface brp_move_if import brp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] move_code;

  modport source (output valid, move_code, input ready);
  modport sink (input valid, move_code, output ready);
endinterface

>>> rtl/button_autorepeat_priority.sv
// Top level: four-button autorepeat with fixed priority and APB registers.
`timescale 1ns / 1ps

// Takes one poll item per cycle while poll.ready is high and returns one move
// item per poll: the poll passes through the input register, then the priority
// and repeat logic writes the result register and the button state together.
// Polls keep flowing back to back while the output is taken every cycle; a
// stalled result holds the input register, which then blocks after one more
// poll. Buttons are ranked down, up, then right and left as equals; right and
// left held together give no move. Register changes apply to intervals loaded
// afterwards.
module button_autorepeat_priority import brp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  brp_poll_if.sink    poll,
  brp_move_if.source  move,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [INTV_W-1:0] init_delay;
  logic [INTV_W-1:0] repeat_rate;
  logic [INTV_W-1:0] down_init_delay;
  logic [INTV_W-1:0] down_repeat;
  reg_idx_t          reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      init_delay      <= INIT_DELAY_RST;
      repeat_rate     <= REPEAT_RATE_RST;
      down_init_delay <= DOWN_INIT_DELAY_RST;
      down_repeat     <= DOWN_REPEAT_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_INIT_DELAY:      init_delay      <= pwdata[INTV_W-1:0];
        REG_REPEAT_RATE:     repeat_rate     <= pwdata[INTV_W-1:0];
        REG_DOWN_INIT_DELAY: down_init_delay <= pwdata[INTV_W-1:0];
        REG_DOWN_REPEAT:     down_repeat     <= pwdata[INTV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_INIT_DELAY:      prdata = {16'b0, init_delay};
      REG_REPEAT_RATE:     prdata = {16'b0, repeat_rate};
      REG_DOWN_INIT_DELAY: prdata = {16'b0, down_init_delay};
      REG_DOWN_REPEAT:     prdata = {16'b0, down_repeat};
      default:             prdata = '0;
    endcase
  end

  // input register
  logic             in_valid;
  logic [NOW_W-1:0] in_now;
  logic             in_left_p;
  logic             in_right_p;
  logic             in_up_p;
  logic             in_down_p;
  logic             advance;

  // result register
  logic              out_valid;
  logic [CODE_W-1:0] out_code;

  assign advance    = in_valid && (!out_valid || move.ready);
  assign poll.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (poll.ready) begin
      in_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      in_now     <= poll.now_ms;
      in_left_p  <= !poll.left_level;
      in_right_p <= !poll.right_level;
      in_up_p    <= !poll.up_level;
      in_down_p  <= !poll.down_level;
    end
  end

  btn_ctl_t ctl_down, ctl_up, ctl_right, ctl_left;
  logic     fire_down, fire_up, fire_right, fire_left;
  logic     lr_ok;
  logic [CODE_W-1:0] code_next;

  assign lr_ok = !in_down_p && !in_up_p && !(in_left_p && in_right_p);

  assign ctl_down  = '{en: advance, pressed: in_down_p};
  assign ctl_up    = '{en: advance && !in_down_p, pressed: in_up_p};
  assign ctl_right = '{en: advance && lr_ok, pressed: in_right_p};
  assign ctl_left  = '{en: advance && lr_ok, pressed: in_left_p};

  brp_button u_down (
    .clk(clk), .rst(rst), .ctl(ctl_down), .now_ms(in_now),
    .reload(down_init_delay), .rate(down_repeat), .fire(fire_down)
  );
  brp_button u_up (
    .clk(clk), .rst(rst), .ctl(ctl_up), .now_ms(in_now),
    .reload(init_delay), .rate(repeat_rate), .fire(fire_up)
  );
  brp_button u_right (
    .clk(clk), .rst(rst), .ctl(ctl_right), .now_ms(in_now),
    .reload(init_delay), .rate(repeat_rate), .fire(fire_right)
  );
  brp_button u_left (
    .clk(clk), .rst(rst), .ctl(ctl_left), .now_ms(in_now),
    .reload(init_delay), .rate(repeat_rate), .fire(fire_left)
  );

  always_comb begin
    if (in_down_p) begin
      code_next = fire_down ? CODE_DOWN : CODE_NONE;
    end else if (in_up_p) begin
      code_next = fire_up ? CODE_ROTATE : CODE_NONE;
    end else if (!lr_ok) begin
      code_next = CODE_NONE;
    end else begin
      code_next = (fire_right ? CODE_RIGHT : CODE_NONE) |
                  (fire_left ? CODE_LEFT : CODE_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (move.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_code <= code_next;
    end
  end

  assign move.valid     = out_valid;
  assign move.move_code = out_code;

  a_adv_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result register not loaded after advance");

  a_down_code: assert property (@(posedge clk) disable iff (rst)
    (advance && in_down_p) |=> (out_code == CODE_NONE || out_code == CODE_DOWN))
    else $error("down held but other move reported");

  a_lr_block: assert property (@(posedge clk) disable iff (rst)
    (advance && !in_down_p && !in_up_p && in_left_p && in_right_p) |=>
      (out_code == CODE_NONE))
    else $error("right and left together produced a move");

  a_code_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(out_code))
    else $error("move code not one-hot");

endmodule

>>> rtl/brp_button.sv
// Per-button repeat state: event time, interval and released flag.
`timescale 1ns / 1ps

module brp_button import brp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  btn_ctl_t          ctl,
  input  logic [NOW_W-1:0]  now_ms,
  input  logic [INTV_W-1:0] reload,
  input  logic [INTV_W-1:0] rate,
  output logic              fire
);

  logic [NOW_W-1:0]  last_time;
  logic [INTV_W-1:0] interval;
  logic              released;
  logic [NOW_W-1:0]  elapsed;
  logic              expired;

  assign elapsed = now_ms - last_time;
  assign expired = elapsed > {{(NOW_W-INTV_W){1'b0}}, interval};
  assign fire    = ctl.pressed && (released || expired);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time <= '0;
      interval  <= INIT_DELAY_RST;
      released  <= 1'b1;
    end else if (ctl.en) begin
      if (ctl.pressed) begin
        if (released) begin
          released <= 1'b0;
        end else if (expired) begin
          last_time <= now_ms;
          interval  <= rate;
        end
      end else begin
        last_time <= now_ms;
        if (!released) begin
          released <= 1'b1;
          interval <= reload;
        end
      end
    end
  end

endmodule
